// File: rtl/cwed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwed_pkg
// Shared widths, register codes, item type and binomial row builder for the
// enumerative constant-weight decoder.
// ----------------------------------------------------------------------------
package cwed_pkg;

  localparam int IDX_W  = 61;   // enumeration index and binomial width
  localparam int CFG_W  = 7;    // length and weight register width
  localparam int WORD_W = 64;   // decoded word width
  localparam int KMAX   = 64;   // largest binomial lower argument kept

  // Configuration register codes
  typedef enum logic [0:0] {
    REG_LENGTH = 1'b0,
    REG_WEIGHT = 1'b1
  } cfg_reg_t;

  // One row of Pascal's triangle, entries 0..KMAX
  typedef logic [KMAX:0][IDX_W-1:0] binom_row_t;

  // Item travelling down the cell chain
  typedef struct packed {
    logic [IDX_W-1:0]  idx;    // remaining index
    logic [CFG_W-1:0]  w;      // remaining weight
    logic [WORD_W-1:0] word;   // bits decided so far
    logic              err;    // index out of range
  } cwed_item_t;

  // Build row m of Pascal's triangle: C(m,k), zero for k > m
  function automatic binom_row_t binom_row(input int m);
    binom_row_t row;
    row    = '0;
    row[0] = IDX_W'(1);
    for (int n = 1; n <= m; n++) begin
      for (int k = n; k >= 1; k--) begin
        row[k] = row[k] + row[k-1];
      end
    end
    return row;
  endfunction

endpackage

// File: rtl/constant_weight_enum_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// constant_weight_enum_decoder
// Turns a one-based enumeration index into the constant-weight word of the
// configured length and weight.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one index per item, valid/ready handshake.
//   out_* : decoded word and index error flag, valid/ready handshake. A bad
//           index (zero or above C(length, weight)) gives the flag and a
//           zero word.
//   cfg_* : writes code_length (index 0) and code_weight (index 1); always
//           ready. Write only while no item is in flight.
// Pipeline: one entry stage, then a chain of MAX_LEN cells, one per bit
//   position, each doing one 61-bit compare-subtract against its constant
//   binomial row.
// Throughput: one item per cycle while out_ready is high. Each stage accepts
//   when it is empty or its item moves on, so bubbles close up and new items
//   enter while a result waits at the output.
// Reset: clears all stage valid bits; length returns to 64, weight to 32.
// Stall: when out_ready is low the result holds and items pile up behind
//   it; in_ready drops once every stage is full.
// Lengths above MAX_LEN are treated as MAX_LEN.
// ----------------------------------------------------------------------------
module constant_weight_enum_decoder
  import cwed_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  // input items
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IDX_W-1:0]  in_code_index,
  // result items
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_code_word,
  output logic              out_index_error
);

  localparam logic [CFG_W-1:0] LEN_CAP = CFG_W'(MAX_LEN);

  logic [CFG_W-1:0] len_r;
  logic [CFG_W-1:0] len_nxt;
  logic [CFG_W-1:0] weight_r;
  logic [CFG_W-1:0] weight_nxt;
  logic [CFG_W-1:0] len_eff;

  logic       stg_valid [0:MAX_LEN];
  logic       stg_ready [0:MAX_LEN];
  cwed_item_t stg_item  [0:MAX_LEN];

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_comb begin
    len_nxt    = len_r;
    weight_nxt = weight_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_LENGTH: len_nxt    = cfg_wdata;
        REG_WEIGHT: weight_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= CFG_W'(64);
      weight_r <= CFG_W'(32);
    end else begin
      len_r    <= len_nxt;
      weight_r <= weight_nxt;
    end
  end

  // Saturate length to the number of cells
  assign len_eff = (len_r > LEN_CAP) ? LEN_CAP : len_r;

  // Entry stage
  cwed_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .len_eff   (len_eff),
    .weight    (weight_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_idx    (in_code_index),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_item  (stg_item[0])
  );

  // Cell chain: first cell has the most positions left
  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    cwed_cell #(
      .R (MAX_LEN - 1 - j)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .len_eff   (len_eff),
      .in_valid  (stg_valid[j]),
      .in_ready  (stg_ready[j]),
      .in_item   (stg_item[j]),
      .out_valid (stg_valid[j+1]),
      .out_ready (stg_ready[j+1]),
      .out_item  (stg_item[j+1])
    );
  end

  // Drive results; drop the word on a bad index
  assign stg_ready[MAX_LEN] = out_ready;
  assign out_valid          = stg_valid[MAX_LEN];
  assign out_index_error    = stg_item[MAX_LEN].err;
  assign out_code_word      = stg_item[MAX_LEN].err ? '0 : stg_item[MAX_LEN].word;

  // With no result waiting, the whole chain can take an item
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

// File: rtl/cwed_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwed_front
// Entry stage: screens the zero index and the empty-word case, loads the
// starting weight and registers the item for the cell chain.
// ----------------------------------------------------------------------------
module cwed_front
  import cwed_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] len_eff,
  input  logic [CFG_W-1:0] weight,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IDX_W-1:0] in_idx,
  output logic             out_valid,
  input  logic             out_ready,
  output cwed_item_t       out_item
);

  logic       v_r;
  logic       v_nxt;
  cwed_item_t item_r;
  cwed_item_t item_nxt;
  logic       empty_bad;

  // Accept when empty or when the held item moves on
  assign in_ready = !v_r || out_ready;

  // Empty word: only index 1 with weight 0 is valid
  assign empty_bad = (len_eff == '0) &&
                     ((in_idx != IDX_W'(1)) || (weight != '0));

  // Build the entering item
  always_comb begin
    item_nxt.idx  = in_idx;
    item_nxt.w    = weight;
    item_nxt.word = '0;
    item_nxt.err  = (in_idx == '0) || empty_bad;
  end

  // Valid bit follows the handshake on both sides
  always_comb begin
    v_nxt = v_r;
    if (in_ready) begin
      v_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_item  = item_r;

  // A zero index always leaves flagged
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_idx == '0)) |=> (v_r && item_r.err))
    else $error("zero index entered without error flag");

endmodule

// File: rtl/cwed_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwed_cell
// One position of the decoder. The cell owns a fixed count of positions left
// after its own, compares the remaining index with the binomial for that
// count and the remaining weight, and sets its bit when the index is larger.
// ----------------------------------------------------------------------------
module cwed_cell
  import cwed_pkg::*;
#(
  parameter int R = 0   // positions left after this one
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] len_eff,
  input  logic             in_valid,
  output logic             in_ready,
  input  cwed_item_t       in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output cwed_item_t       out_item
);

  localparam binom_row_t ROW_REM = binom_row(R);       // C(R, k)
  localparam binom_row_t ROW_TOT = binom_row(R + 1);   // C(R+1, k)
  localparam logic [CFG_W-1:0] R_C = CFG_W'(R);
  localparam logic [CFG_W-1:0] K_LIM = CFG_W'(KMAX);

  logic             v_r;
  logic             v_nxt;
  cwed_item_t       item_r;
  cwed_item_t       item_nxt;
  logic             active;
  logic             first;
  logic [IDX_W-1:0] c_rem;
  logic [IDX_W-1:0] c_tot;
  logic [CFG_W-1:0] pos;
  logic             take;

  // Cell works only on positions inside the configured length
  assign active = (R_C < len_eff);
  assign first  = (R_C == (len_eff - CFG_W'(1)));
  assign pos    = len_eff - CFG_W'(1) - R_C;

  // Look up binomials; zero past the table
  assign c_rem = (in_item.w <= K_LIM) ? ROW_REM[in_item.w] : '0;
  assign c_tot = (in_item.w <= K_LIM) ? ROW_TOT[in_item.w] : '0;

  assign take = active && (in_item.idx > c_rem) && (in_item.w != '0);

  // Compare, subtract and set the bit
  always_comb begin
    item_nxt = in_item;
    if (take) begin
      item_nxt.idx             = in_item.idx - c_rem;
      item_nxt.w               = in_item.w - CFG_W'(1);
      item_nxt.word[pos[5:0]]  = 1'b1;
    end
    if (first && (in_item.idx > c_tot)) begin
      item_nxt.err = 1'b1;
    end
  end

  // Accept when empty or when the held item moves on
  assign in_ready = !v_r || out_ready;

  always_comb begin
    v_nxt = v_r;
    if (in_ready) begin
      v_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_item  = item_r;

  // An accepted item occupies the cell next cycle
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r)
    else $error("accepted item lost in cell");

  // A blocked item holds its contents
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && !out_ready) |=> (v_r && $stable(item_r)))
    else $error("blocked item changed in cell");

endmodule
